@@ src/ltc_pkg.sv @@
// Shared types and constants for the LRU tag cache.
package ltc_pkg;

  localparam int TAG_W  = 32;
  localparam int SIZE_W = 31;
  localparam int CFG_W  = 5;
  localparam int SLOT_OUT_W = 4;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [TAG_W-1:0]  key_tag;
    logic [SIZE_W-1:0] item_size;
  } ltc_req_t;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic [SIZE_W-1:0]     stored_size;
    logic                  evicted;
    logic [TAG_W-1:0]      evicted_tag;
  } ltc_rsp_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
  } ltc_data_t;

  typedef struct packed {
    logic live;
    logic shift;
  } ltc_cell_ctl_t;

endpackage

@@ src/ltc_cell.sv @@
// One recency position of the cache: holds an entry, compares it, shifts along the row.
module ltc_cell
  import ltc_pkg::*;
#(
  parameter int SLOT_W = 4
) (
  input  logic              clk,
  input  ltc_cell_ctl_t     ctl,
  input  logic [TAG_W-1:0]  key,
  input  ltc_data_t         prev_data,
  input  logic [SLOT_W-1:0] prev_slot,
  output ltc_data_t         data,
  output logic [SLOT_W-1:0] slot,
  output logic              match
);

  // take the neighbour's entry when the row shifts through this position
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data <= prev_data;
      slot <= prev_slot;
    end
  end

  assign match = ctl.live && (data.tag == key);

endmodule

@@ src/lru_tag_cache_top.sv @@
// Top level of the fully associative LRU tag cache.
//
// A fully associative table of ENTRIES slots with least-recently-used
// replacement, built as a row of cells ordered by recency: cell 0 holds the
// most recent entry, cell occupancy-1 the least recent. Each request carries
// a key tag and a size. All occupied cells compare the tag at once; on a hit
// the cells ahead of the matching one shift back by one and the matching
// entry drops into cell 0, and its stored size is returned. On a miss the new
// tag and size enter cell 0; if the table already holds capacity_limit
// entries (0 acts as 1, anything above ENTRIES as ENTRIES) the least recent
// entry is evicted and its slot reused, otherwise the next free slot is
// taken. Occupancy never shrinks, even if the limit is lowered later.
// Rate: one request per clock while rsp is not stalled; a request is held in
// the request register, then the single compare-and-shift step of the cell
// row updates the whole recency order and loads the result into rsp. The
// request register is held while rsp is stalled. The configuration port
// always accepts; write capacity_limit only while the cache is idle.
module lru_tag_cache_top
  import ltc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  ltc_req_t         req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output ltc_rsp_t         rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // control state
  logic [CFG_W-1:0] cap;
  logic [CNT_W-1:0] cnt;
  logic             pend_valid;
  ltc_req_t         pend;
  logic             adv;

  // cell row
  ltc_data_t         data_q    [ENTRIES];
  logic [SLOT_W-1:0] slot_q    [ENTRIES];
  ltc_data_t         prev_data [ENTRIES];
  logic [SLOT_W-1:0] prev_slot [ENTRIES];
  ltc_cell_ctl_t     ctl       [ENTRIES];
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] last;

  // lookup results
  logic              hit;
  logic              full;
  logic              evict;
  logic [CFG_W-1:0]  cap_eff;
  logic [TAG_W-1:0]  vic_tag;
  logic [SLOT_W-1:0] vic_slot;
  logic [SIZE_W-1:0] hit_size;
  logic [SLOT_W-1:0] hit_slot;
  logic [CNT_W-1:0]  hit_pos;
  logic [CNT_W-1:0]  tpos;
  ltc_data_t         head_data;
  logic [SLOT_W-1:0] head_slot;

  // configuration: always ready, capacity latched on each write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap <= cfg_data;
    end
  end

  // request register: advance when the response register is free or draining
  assign adv       = pend_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = pend_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      pend_valid <= 1'b1;
    end else if (adv) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      pend <= req;
    end
  end

  // gather the matching entry and the least recent entry by one-hot selection
  always_comb begin
    hit_size = '0;
    hit_slot = '0;
    hit_pos  = '0;
    vic_tag  = '0;
    vic_slot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hit_size = hit_size | data_q[i].size;
        hit_slot = hit_slot | slot_q[i];
        hit_pos  = hit_pos | CNT_W'(i);
      end
      if (last[i]) begin
        vic_tag  = vic_tag | data_q[i].tag;
        vic_slot = vic_slot | slot_q[i];
      end
    end
  end

  assign hit     = |match;
  assign full    = (cnt == CNT_W'(ENTRIES));
  assign cap_eff = (cap == '0) ? CFG_W'(1) : cap;
  assign evict   = !hit && (full || (CMP_W'(cnt) >= CMP_W'(cap_eff)));

  // deepest recency position that moves this cycle
  always_comb begin
    if (hit) begin
      tpos = hit_pos;
    end else if (evict) begin
      tpos = CNT_W'(cnt - 1'b1);
    end else begin
      tpos = cnt;
    end
  end

  // entry dropping into the most recent position
  always_comb begin
    if (hit) begin
      head_data.tag  = pend.key_tag;
      head_data.size = hit_size;
      head_slot      = hit_slot;
    end else begin
      head_data.tag  = pend.key_tag;
      head_data.size = pend.item_size;
      head_slot      = evict ? vic_slot : SLOT_W'(cnt);
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_data[i] = head_data;
      assign prev_slot[i] = head_slot;
    end else begin : g_body
      assign prev_data[i] = data_q[i-1];
      assign prev_slot[i] = slot_q[i-1];
    end

    assign ctl[i].live  = (CNT_W'(i) < cnt);
    assign ctl[i].shift = adv && (CNT_W'(i) <= tpos);
    assign last[i]      = (CNT_W'(i + 1) == cnt);

    ltc_cell #(
      .SLOT_W (SLOT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .key       (pend.key_tag),
      .prev_data (prev_data[i]),
      .prev_slot (prev_slot[i]),
      .data      (data_q[i]),
      .slot      (slot_q[i]),
      .match     (match[i])
    );
  end

  // occupancy grows only on a miss that takes a free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (adv && !hit && !evict) begin
      cnt <= CNT_W'(cnt + 1'b1);
    end
  end

  // response register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.hit         <= hit;
      rsp.slot        <= SLOT_OUT_W'(head_slot);
      rsp.stored_size <= head_data.size;
      rsp.evicted     <= evict;
      rsp.evicted_tag <= evict ? vic_tag : '0;
    end
  end

  // occupancy stays within the table
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(ENTRIES))
    else $error("occupancy beyond table size");

  // tags in the table are unique, so at most one cell matches
  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("more than one cell matched");

  // a miss into a free slot grows occupancy by one
  a_cnt_grow: assert property (@(posedge clk) disable iff (rst)
    (adv && !hit && !evict) |=> (cnt == CNT_W'($past(cnt) + 1'b1)))
    else $error("occupancy did not grow on insert");

  // an eviction only happens with the table non-empty
  a_evict_nonempty: assert property (@(posedge clk) disable iff (rst)
    (adv && evict) |-> (cnt != '0))
    else $error("eviction from an empty table");

endmodule
